>>> hw/rtl/wwgs_pkg.sv
// Package for the Wireworld grid stepper: field widths, cell and operation codes,
// register indexes and the command and status structs between controller and datapath.
// No dependencies.
package wwgs_pkg;

  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 6;
  localparam int CELL_W   = 2;
  localparam int GEN_W    = 16;
  localparam int CFG_W    = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CFG_W-1:0] ROWS_IN_USE_RST = 7'd40;
  localparam logic [CFG_W-1:0] COLS_IN_USE_RST = 7'd40;

  localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [CELL_W-1:0] CELL_WIRE  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_HEAD  = 2'd2;
  localparam logic [CELL_W-1:0] CELL_TAIL  = 2'd3;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;

  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic cnt_clear;
    logic cnt_inc;
    logic clr_wr;
    logic cap_item;
    logic acc_rd;
    logic acc_wr;
    logic rd_cap;
    logic step_en;
    logic step_done;
    logic load_out;
  } wwgs_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                in_use;
    logic                clear_last;
    logic                step_last;
    logic                out_free;
  } wwgs_sts_t;

endpackage

>>> hw/rtl/wwgs_if.sv
// Valid/ready channel interfaces for the Wireworld grid stepper items and results.
// Depends on wwgs_pkg for the field widths.
interface wwgs_in_if import wwgs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic [CELL_W-1:0]   new_state;

  modport source (output valid, output opcode, output row, output col, output new_state,
                  input ready);
  modport sink (input valid, input opcode, input row, input col, input new_state,
                output ready);
endinterface

interface wwgs_out_if import wwgs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [GEN_W-1:0]  generation;

  modport source (output valid, output cell_value, output generation, input ready);
  modport sink (input valid, input cell_value, input generation, output ready);
endinterface

>>> hw/rtl/wwgs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wwgs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/wwgs_regs.sv
// APB register file holding the rows and columns in use.
// Depends on wwgs_pkg for widths, reset values and register indexes.
module wwgs_regs import wwgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CFG_W-1:0]  rows_in_use_o,
  output logic [CFG_W-1:0]  cols_in_use_o
);

  logic [CFG_W-1:0] rows_q, rows_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      case (paddr[2])
        REG_ROWS_IN_USE: rows_d = pwdata[CFG_W-1:0];
        REG_COLS_IN_USE: cols_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_IN_USE_RST;
      cols_q <= COLS_IN_USE_RST;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS_IN_USE: prdata = APB_DW'(rows_q);
      REG_COLS_IN_USE: prdata = APB_DW'(cols_q);
      default:         prdata = '0;
    endcase
  end

  assign rows_in_use_o = rows_q;
  assign cols_in_use_o = cols_q;

endmodule

>>> hw/rtl/wwgs_ctrl.sv
// Controller state machine of the Wireworld grid stepper: clearing pass, cell access,
// generation sweep and result hand-off. Depends on wwgs_pkg for the command and status structs.
module wwgs_ctrl import wwgs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  wwgs_sts_t sts_i,
  output wwgs_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ACCESS,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.op)
          OP_WRITE, OP_READ: begin
            if (sts_i.in_use) begin
              cmd_o.acc_rd = 1'b1;
              state_d      = ST_ACCESS;
            end else begin
              state_d = ST_DONE;
            end
          end
          OP_STEP: begin
            cmd_o.cnt_clear = 1'b1;
            state_d         = ST_STEP;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_ACCESS: begin
        case (sts_i.op)
          OP_WRITE: cmd_o.acc_wr = 1'b1;
          OP_READ:  cmd_o.rd_cap = 1'b1;
          default: ;
        endcase
        state_d = ST_DONE;
      end
      ST_STEP: begin
        cmd_o.step_en = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.step_last) begin
          cmd_o.step_done = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("Result loaded while the output register is still occupied.");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step_en || cmd_o.clr_wr) |-> !in_ready_o)
    else $error("Input offered as ready during a sweep of the grid.");

endmodule

>>> hw/rtl/wwgs_datapath.sv
// Datapath of the Wireworld grid stepper: item and window registers, row update logic,
// RAM port multiplexing, generation counter and output register. Depends on wwgs_pkg.
module wwgs_datapath import wwgs_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wwgs_cmd_t                     cmd_i,
  output wwgs_sts_t                     sts_o,
  input  logic [OPCODE_W-1:0]           opcode_i,
  input  logic [COORD_W-1:0]            row_i,
  input  logic [COORD_W-1:0]            col_i,
  input  logic [CELL_W-1:0]             new_state_i,
  input  logic [CFG_W-1:0]              rows_in_use_i,
  input  logic [CFG_W-1:0]              cols_in_use_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [CELL_W-1:0]             cell_value_o,
  output logic [GEN_W-1:0]              generation_o,
  output logic                          ram_we_o,
  output logic [$clog2(ROWS):0]         ram_waddr_o,
  output logic [CELL_W*COLS-1:0]        ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(ROWS):0]         ram_raddr_o,
  input  logic [CELL_W*COLS-1:0]        ram_rdata_i
);

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int AW   = RW + 1;
  localparam int CNTW = $clog2(ROWS + 2);
  localparam int MW   = (CNTW > CFG_W) ? CNTW : CFG_W;
  localparam int ECW  = $clog2(COLS + 1);
  localparam int MWC  = (ECW > CFG_W) ? ECW : CFG_W;

  typedef logic [COLS-1:0][CELL_W-1:0] row_t;

  logic [OPCODE_W-1:0] op_q;
  logic [COORD_W-1:0]  row_q, col_q;
  logic [CELL_W-1:0]   ns_q;
  logic                sel_q;
  logic [GEN_W-1:0]    gen_q;
  logic [CNTW-1:0]     cnt_q, cnt_d, cnt_m2;
  row_t                mid_q;
  logic                mid_use_q;
  logic [COLS-1:0]     hv_above_q, hv_mid_q, hv_b, col_use;
  logic [COLS+1:0]     pad_a, pad_m, pad_b;
  logic [CELL_W-1:0]   rd_val_q, out_cell_q;
  logic [GEN_W-1:0]    out_gen_q;
  logic                out_valid_q;
  logic [MW-1:0]       eff_rows;
  logic [MWC-1:0]      eff_cols;
  logic                item_in_use, below_valid, below_use;
  row_t                rd_row, merged_row, next_row;
  logic [RW-1:0]       item_row, step_wr_row;
  logic [CW-1:0]       item_col;

  assign eff_rows = (MW'(rows_in_use_i) > MW'(ROWS)) ? MW'(ROWS) : MW'(rows_in_use_i);
  assign eff_cols = (MWC'(cols_in_use_i) > MWC'(COLS)) ? MWC'(COLS) : MWC'(cols_in_use_i);

  assign item_in_use = (MW'(row_q) < eff_rows) && (MWC'(col_q) < eff_cols);
  assign item_row    = RW'(row_q);
  assign item_col    = CW'(col_q);
  assign rd_row      = ram_rdata_i;

  always_comb begin
    merged_row           = rd_row;
    merged_row[item_col] = ns_q;
  end

  assign below_valid = (cnt_q != '0) && (cnt_q <= CNTW'(ROWS));
  assign below_use   = below_valid && (MW'(cnt_q) <= eff_rows);
  assign cnt_m2      = cnt_q - CNTW'(2);
  assign step_wr_row = cnt_m2[RW-1:0];

  assign pad_a = {1'b0, hv_above_q, 1'b0};
  assign pad_m = {1'b0, hv_mid_q, 1'b0};
  assign pad_b = {1'b0, hv_b, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic [3:0]        heads;
    logic [CELL_W-1:0] cell_next;

    assign col_use[c] = MWC'(c) < eff_cols;
    assign hv_b[c]    = below_use && col_use[c] && (rd_row[c] == CELL_HEAD);
    assign heads = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2]) + 4'(pad_m[c])
                 + 4'(pad_m[c+2]) + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);

    always_comb begin
      cell_next = mid_q[c];
      if (mid_use_q && col_use[c]) begin
        case (mid_q[c])
          CELL_HEAD: cell_next = CELL_TAIL;
          CELL_TAIL: cell_next = CELL_WIRE;
          CELL_WIRE: cell_next = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_WIRE;
          default:   cell_next = CELL_EMPTY;
        endcase
      end
    end

    assign next_row[c] = cell_next;
  end

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = {sel_q, item_row};
    ram_wdata_o = merged_row;
    ram_re_o    = 1'b0;
    ram_raddr_o = {sel_q, item_row};
    if (cmd_i.clr_wr) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = {1'b0, cnt_q[RW-1:0]};
      ram_wdata_o = '0;
    end else if (cmd_i.acc_wr) begin
      ram_we_o = 1'b1;
    end else if (cmd_i.step_en && cnt_q >= CNTW'(2)) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = {~sel_q, step_wr_row};
      ram_wdata_o = next_row;
    end
    if (cmd_i.acc_rd) begin
      ram_re_o = 1'b1;
    end else if (cmd_i.step_en && cnt_q < CNTW'(ROWS)) begin
      ram_re_o    = 1'b1;
      ram_raddr_o = {sel_q, cnt_q[RW-1:0]};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sel_q       <= 1'b0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.step_done) begin
        sel_q <= ~sel_q;
        gen_q <= gen_q + GEN_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      op_q  <= opcode_i;
      row_q <= row_i;
      col_q <= col_i;
      ns_q  <= new_state_i;
    end
    if (cmd_i.rd_cap) begin
      rd_val_q <= rd_row[item_col];
    end
    if (cmd_i.cnt_clear) begin
      mid_q      <= '0;
      mid_use_q  <= 1'b0;
      hv_mid_q   <= '0;
      hv_above_q <= '0;
    end else if (cmd_i.step_en) begin
      mid_q      <= below_valid ? rd_row : '0;
      mid_use_q  <= below_use;
      hv_mid_q   <= hv_b;
      hv_above_q <= hv_mid_q;
    end
    if (cmd_i.load_out) begin
      out_cell_q <= (op_q == OP_READ && item_in_use) ? rd_val_q : CELL_EMPTY;
      out_gen_q  <= gen_q;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.in_use     = item_in_use;
  assign sts_o.clear_last = cnt_q == CNTW'(ROWS - 1);
  assign sts_o.step_last  = cnt_q == CNTW'(ROWS + 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_cell_q;
  assign generation_o = out_gen_q;

  a_step_writes_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step_en && ram_we_o) |-> (ram_waddr_o[AW-1] != sel_q))
    else $error("Generation sweep wrote into the current buffer.");

  a_access_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_rd || cmd_i.acc_wr) |-> item_in_use)
    else $error("Cell access issued for a cell outside the region in use.");

  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && op_q != OP_READ) |=> (out_cell_q == CELL_EMPTY))
    else $error("Non-zero cell value reported for an item that is not a read.");

endmodule

>>> hw/rtl/wireworld_grid_stepper_top.sv
// Top level of the Wireworld grid stepper: registers, controller, datapath and grid RAM.
// Depends on wwgs_pkg, wwgs_if, wwgs_ram, wwgs_regs, wwgs_ctrl and wwgs_datapath.
//
// Items arrive on in_i; each transfer writes one cell, reads one cell, advances the whole
// grid by one generation or, with the unused opcode, does nothing. Every item gives exactly
// one result on out_o, carrying the cell read (zero otherwise) and the generation count
// after the item. The region in use is set through the APB port and may be changed whenever
// the block is idle. The grid is held one row per RAM word in two buffers that swap after
// every generation. A read or write of a cell in use passes through the dispatch, access
// and done states before its result is loaded; one out of use skips the access state.
// A generation reads one row a cycle through the single read port; a new item is taken in
// the cycle after a result is loaded. After reset the current buffer is cleared one row a
// cycle, all ROWS rows, with in_i not ready; configuration writes are taken meanwhile.
// While the receiver stalls, the result waits in the output register; the block still
// takes and works on one further item and then holds it until the register is free.
module wireworld_grid_stepper_top import wwgs_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wwgs_in_if.sink           in_i,
  wwgs_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int RAM_AW    = $clog2(ROWS) + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int RAM_W     = CELL_W * COLS;

  wwgs_cmd_t          cmd;
  wwgs_sts_t          sts;
  logic [CFG_W-1:0]   rows_in_use;
  logic [CFG_W-1:0]   cols_in_use;
  logic               ram_we, ram_re;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;

  wwgs_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .rows_in_use_o (rows_in_use),
    .cols_in_use_o (cols_in_use)
  );

  wwgs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wwgs_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_i.opcode),
    .row_i         (in_i.row),
    .col_i         (in_i.col),
    .new_state_i   (in_i.new_state),
    .rows_in_use_i (rows_in_use),
    .cols_in_use_i (cols_in_use),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .cell_value_o  (out_o.cell_value),
    .generation_o  (out_o.generation),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  wwgs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RAM_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> verif/wwgs_checker.sv
// Checker for the Wireworld grid stepper: watches the item, result and APB channels,
// keeps its own copy of the grid and region, and compares every result transfer.
// Depends on wwgs_pkg and on the wwgs_in_if and wwgs_out_if interfaces.
module wwgs_checker import wwgs_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wwgs_in_if                items_i,
  wwgs_out_if               results_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                awaiting_o,
  output int                failures_o
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [GEN_W-1:0]  generation;
  } result_t;

  logic [CELL_W-1:0] grid_q [ROWS][COLS];
  logic [GEN_W-1:0]  gen_count;
  logic [CFG_W-1:0]  rows_cfg;
  logic [CFG_W-1:0]  cols_cfg;
  result_t           pending_results [$];
  int                fail_count;

  function automatic int region_extent(logic [CFG_W-1:0] value, int limit);
    return (int'(value) > limit) ? limit : int'(value);
  endfunction

  function automatic int heads_near(int r, int c, int nr, int nc);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 && r + dr < nr &&
            c + dc < nc && grid_q[r+dr][c+dc] == CELL_HEAD) begin
          n++;
        end
      end
    end
    return n;
  endfunction

  function automatic void advance_generation();
    logic [CELL_W-1:0] nxt [ROWS][COLS];
    int nr;
    int nc;
    int heads;
    nr = region_extent(rows_cfg, ROWS);
    nc = region_extent(cols_cfg, COLS);
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        nxt[r][c] = grid_q[r][c];
        if (r < nr && c < nc) begin
          case (grid_q[r][c])
            CELL_HEAD: nxt[r][c] = CELL_TAIL;
            CELL_TAIL: nxt[r][c] = CELL_WIRE;
            CELL_WIRE: begin
              heads = heads_near(r, c, nr, nc);
              nxt[r][c] = (heads == 1 || heads == 2) ? CELL_HEAD : CELL_WIRE;
            end
            default: nxt[r][c] = CELL_EMPTY;
          endcase
        end
      end
    end
    grid_q = nxt;
    gen_count = gen_count + 1'b1;
  endfunction

  function automatic result_t apply_item(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] r,
                                         logic [COORD_W-1:0] c, logic [CELL_W-1:0] ns);
    result_t res;
    logic    hit;
    hit = int'(r) < region_extent(rows_cfg, ROWS) && int'(c) < region_extent(cols_cfg, COLS);
    res.cell_value = CELL_EMPTY;
    case (op)
      OP_WRITE: if (hit) grid_q[r][c] = ns;
      OP_READ:  if (hit) res.cell_value = grid_q[r][c];
      OP_STEP:  advance_generation();
      default:  ;
    endcase
    res.generation = gen_count;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    logic    got_item;
    logic    got_result;
    if (!rst_ni) begin
      foreach (grid_q[r, c]) grid_q[r][c] = CELL_EMPTY;
      gen_count = '0;
      rows_cfg = ROWS_IN_USE_RST;
      cols_cfg = COLS_IN_USE_RST;
      pending_results.delete();
      fail_count = 0;
      awaiting_o <= 0;
      failures_o <= 0;
    end else begin
      got_item = items_i.valid && items_i.ready;
      got_result = results_i.valid && results_i.ready;
      if (got_result) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected result cell_value %0d generation %0d", $time,
                     results_i.cell_value, results_i.generation);
          end
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.cell_value !== results_i.cell_value ||
              want.generation !== results_i.generation) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch cell_value exp %0d got %0d, generation exp %0d got %0d",
                       $time, want.cell_value, results_i.cell_value, want.generation,
                       results_i.generation);
            end
            fail_count++;
          end
        end
      end
      if (got_item) begin
        pending_results.push_back(apply_item(items_i.opcode, items_i.row, items_i.col,
                                             items_i.new_state));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_ROWS_IN_USE) begin
          rows_cfg = pwdata[CFG_W-1:0];
        end else begin
          cols_cfg = pwdata[CFG_W-1:0];
        end
      end
      awaiting_o <= awaiting_o + int'(got_item) - int'(got_result);
      failures_o <= fail_count;
    end
  end

endmodule

>>> verif/testbench.sv
// Top of the Wireworld grid stepper testbench: clock, reset, item stimulus, result
// back-pressure and region settings over APB, with the verdict taken from the checker.
// Depends on wwgs_pkg, wwgs_if, wireworld_grid_stepper_top and wwgs_checker.
module testbench import wwgs_pkg::*; ();

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int WINDOW = 6;
  localparam int PHASE_ITEMS = 13;
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                awaiting;
  int                failures;
  int                cycle_count;
  int                live_rows;
  int                live_cols;
  int                win_row;
  int                win_col;
  logic              send_burst;
  logic              take_burst;

  wwgs_in_if  item_if ();
  wwgs_out_if result_if ();

  wireworld_grid_stepper_top #(
    .ROWS(GRID_ROWS),
    .COLS(GRID_COLS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (result_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  wwgs_checker #(
    .ROWS(GRID_ROWS),
    .COLS(GRID_COLS)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .items_i   (item_if),
    .results_i (result_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .awaiting_o(awaiting),
    .failures_o(failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wireworld_grid_stepper_top regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [OPCODE_W-1:0] op, input int r, input int c,
                           input logic [CELL_W-1:0] ns);
    int unsigned gap;
    if ($urandom_range(0, 14) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.opcode <= op;
    item_if.row <= COORD_W'(r);
    item_if.col <= COORD_W'(c);
    item_if.new_state <= ns;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[CFG_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_region(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    wait_idle();
    cfg_write(REG_ROWS_IN_USE, rows);
    cfg_write(REG_COLS_IN_USE, cols);
    live_rows = (int'(rows) > GRID_ROWS) ? GRID_ROWS : int'(rows);
    live_cols = (int'(cols) > GRID_COLS) ? GRID_COLS : int'(cols);
    win_row = ($urandom_range(0, 1) == 1 && live_rows > WINDOW) ? live_rows - WINDOW : 0;
    win_col = ($urandom_range(0, 1) == 1 && live_cols > WINDOW) ? live_cols - WINDOW : 0;
  endtask

  task automatic random_item();
    logic [OPCODE_W-1:0] op;
    logic [CELL_W-1:0]   ns;
    int                  r;
    int                  c;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    op = (pick < 45) ? OP_WRITE : (pick < 80) ? OP_READ : (pick < 95) ? OP_STEP : OP_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 70 && live_rows != 0 && live_cols != 0) begin
      r = win_row + $urandom_range(0, ((live_rows < WINDOW) ? live_rows : WINDOW) - 1);
      c = win_col + $urandom_range(0, ((live_cols < WINDOW) ? live_cols : WINDOW) - 1);
    end else if (pick < 85 && live_rows != 0 && live_cols != 0) begin
      r = $urandom_range(0, live_rows - 1);
      c = $urandom_range(0, live_cols - 1);
    end else begin
      r = $urandom_range(0, COORD_MAX);
      c = $urandom_range(0, COORD_MAX);
    end
    pick = $urandom_range(0, 99);
    ns = (pick < 50) ? CELL_WIRE : (pick < 70) ? CELL_HEAD : (pick < 85) ? CELL_TAIL : CELL_EMPTY;
    send_item(op, r, c, ns);
  endtask

  initial begin
    int unsigned stall;
    result_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 14) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_if.valid && result_if.ready));
    end
  end

  initial begin
    logic [CFG_W-1:0] row_settings [8];
    logic [CFG_W-1:0] col_settings [8];
    row_settings = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd5, 7'd3, 7'd40};
    col_settings = '{7'd64, 7'd1, 7'd9, 7'd127, 7'd2, 7'd64, 7'd0, 7'd3};
    cycle_count <= 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    live_rows = int'(ROWS_IN_USE_RST);
    live_cols = int'(COLS_IN_USE_RST);
    win_row = 0;
    win_col = 0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_if.valid <= 1'b0;
    item_if.opcode <= OP_WRITE;
    item_if.row <= '0;
    item_if.col <= '0;
    item_if.new_state <= CELL_EMPTY;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset region: a short wire fed by one head, cells at the edge
    // of the region and outside it, an explicit empty write and the unused opcode.
    send_item(OP_READ, 0, 0, CELL_EMPTY);
    send_item(OP_WRITE, 0, 0, CELL_WIRE);
    send_item(OP_WRITE, 0, 1, CELL_HEAD);
    send_item(OP_WRITE, 0, 2, CELL_WIRE);
    send_item(OP_WRITE, 1, 1, CELL_WIRE);
    send_item(OP_WRITE, 39, 39, CELL_TAIL);
    send_item(OP_WRITE, COORD_MAX, COORD_MAX, CELL_HEAD);
    send_item(OP_WRITE, 40, 0, CELL_WIRE);
    send_item(OP_WRITE, 2, 2, CELL_WIRE);
    send_item(OP_WRITE, 2, 2, CELL_EMPTY);
    send_item(OP_READ, 0, 1, CELL_TAIL);
    send_item(OP_READ, COORD_MAX, COORD_MAX, CELL_WIRE);
    send_item(OP_READ, 40, 0, CELL_HEAD);
    send_item(OP_READ, 39, 39, CELL_EMPTY);
    send_item(OP_NOP, 21, 42, CELL_TAIL);
    send_item(OP_STEP, 0, 0, CELL_EMPTY);
    send_item(OP_READ, 0, 0, CELL_EMPTY);
    send_item(OP_READ, 1, 1, CELL_EMPTY);
    send_item(OP_STEP, COORD_MAX, COORD_MAX, CELL_TAIL);
    send_item(OP_READ, 0, 1, CELL_EMPTY);
    send_item(OP_READ, 0, 2, CELL_EMPTY);
    send_item(OP_READ, 39, 39, CELL_EMPTY);

    for (int p = 0; p < 9; p++) begin
      if (p < 8) begin
        set_region(row_settings[p], col_settings[p]);
      end else begin
        set_region(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 127)));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("wireworld_grid_stepper_top regression: pass");
    end else begin
      $display("wireworld_grid_stepper_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/wwgs_pkg.sv
hw/rtl/wwgs_if.sv
hw/rtl/wwgs_ram.sv
hw/rtl/wwgs_regs.sv
hw/rtl/wwgs_ctrl.sv
hw/rtl/wwgs_datapath.sv
hw/rtl/wireworld_grid_stepper_top.sv
verif/wwgs_checker.sv
verif/testbench.sv
